// ===== src/record_quicksort_by_key_unit_macros.svh =====
// Assertion helpers for the files that check their own logic.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef RECORD_QUICKSORT_BY_KEY_UNIT_MACROS_SVH
`define RECORD_QUICKSORT_BY_KEY_UNIT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define RQS_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the trigger holds, the condition holds in the next cycle.
`define RQS_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== src/rqs_pkg.sv =====
`timescale 1ns / 1ps
package rqs_pkg;

  localparam int KEY_BITS = 32;

  typedef enum logic [1:0] {
    KEY_S16 = 2'd0,
    KEY_S32 = 2'd1,
    KEY_U16 = 2'd2,
    KEY_U32 = 2'd3
  } key_type_t;

  typedef logic signed [KEY_BITS:0] key_rank_t;

  // Maps raw key bits onto one signed scale so a single compare serves all modes.
  function automatic key_rank_t rqs_rank(input logic [KEY_BITS-1:0] k,
                                         input key_type_t kt);
    key_rank_t rk;
    case (kt)
      KEY_S16: rk = key_rank_t'({{(KEY_BITS-15){k[15]}}, k[15:0]});
      KEY_S32: rk = key_rank_t'({k[KEY_BITS-1], k});
      KEY_U16: rk = key_rank_t'({{(KEY_BITS-15){1'b0}}, k[15:0]});
      default: rk = key_rank_t'({1'b0, k});
    endcase
    return rk;
  endfunction

endpackage

// ===== src/rqs_if.sv =====
`timescale 1ns / 1ps
interface rqs_in_if #(parameter int PAYLOAD_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic [31:0]             record_key;
  logic [PAYLOAD_BITS-1:0] record_payload;
  logic                    is_last;
  modport source (output valid, record_key, record_payload, is_last, input ready);
  modport sink (input valid, record_key, record_payload, is_last, output ready);
endinterface

interface rqs_out_if #(parameter int PAYLOAD_BITS = 32);
  logic                    valid;
  logic                    ready;
  logic [31:0]             sorted_key;
  logic [PAYLOAD_BITS-1:0] sorted_payload;
  logic                    last_out;
  logic                    overflow;
  modport source (output valid, sorted_key, sorted_payload, last_out, overflow,
                  input ready);
  modport sink (input valid, sorted_key, sorted_payload, last_out, overflow,
                output ready);
endinterface

interface rqs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_type;
  modport source (output valid, key_type, input ready);
  modport sink (input valid, key_type, output ready);
endinterface

// ===== src/rqs_ram.sv =====
`timescale 1ns / 1ps
module rqs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/record_quicksort_by_key_unit.sv =====
`timescale 1ns / 1ps
// Records load at one request per cycle; after the last one the sort reads and checks one key
// at a time in the partition scans and in the insertion fallback, writes both records of each
// swap and pops ranges off the stack, then results leave one at a time while the sink is ready.
// Throughput is set by the single store read port.
// Reset (rst_n low, synchronous) empties the batch, clears the stack pointer, the drop flag
// and the key mode; the record store itself is not cleared.
`include "record_quicksort_by_key_unit_macros.svh"
module record_quicksort_by_key_unit
  import rqs_pkg::*;
#(
  parameter int MAX_RECORDS  = 64,
  parameter int PAYLOAD_BITS = 32,
  parameter int STACK_DEPTH  = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  rqs_in_if.sink    in_ch,
  rqs_out_if.source out_ch,
  rqs_cfg_if.sink   cfg_ch
);

  // Index arithmetic is signed and one bit wider than the count so that the
  // quicksort bounds can reach minus one and the full batch size.
  localparam int AW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int IW  = CW + 1;
  localparam int RW  = KEY_BITS + PAYLOAD_BITS;
  localparam int SW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  typedef logic signed [IW-1:0] idx_t;
  typedef logic [RW-1:0]        rec_t;

  typedef enum logic [4:0] {
    S_LOAD, S_TOP, S_POP1, S_POP2, S_PIV,
    S_L_RD, S_L_CHK, S_R_RD, S_R_CHK, S_SW1, S_SW2, S_PSW1, S_PSW2, S_SPLIT,
    S_INS_OUT, S_INS_CUR, S_INS_CHK, S_INS_FIN,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  key_type_t     key_type_r;
  logic [SW-1:0] sp_r, sp_nxt;
  idx_t          l_r, l_nxt, r_r, r_nxt, i1_r, i1_nxt, i2_r, i2_nxt;
  idx_t          ilo_r, ilo_nxt, ihi_r, ihi_nxt, ii_r, ii_nxt, j_r, j_nxt;
  key_rank_t     pv_r, pv_nxt;
  rec_t          prec_r, prec_nxt, rec1_r, rec1_nxt, rec2_r, rec2_nxt, cur_r, cur_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  rec_t          out_rec_r, out_rec_nxt;

  // Range stack: written two entries at a time, read one entry per cycle.
  idx_t          stack_r [STACK_DEPTH];
  logic          push_en;
  idx_t          push_lo, push_hi;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  rec_t          ram_wdata, ram_rdata;
  key_rank_t     rd_rank;
  idx_t          split_i, plo, phi;
  logic          in_req, cfg_req;

  rqs_ram #(.WIDTH(RW), .DEPTH(MAX_RECORDS)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ch.ready   = (state_r == S_LOAD);
  assign cfg_ch.ready  = 1'b1;
  assign in_req        = in_ch.valid && in_ch.ready;
  assign cfg_req       = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sorted_key     = out_rec_r[RW-1:PAYLOAD_BITS];
  assign out_ch.sorted_payload = out_rec_r[PAYLOAD_BITS-1:0];
  assign out_ch.last_out       = out_last_r;
  assign out_ch.overflow       = out_ovf_r;

  assign rd_rank = rqs_rank(ram_rdata[RW-1:PAYLOAD_BITS], key_type_r);
  assign split_i = i1_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    sp_nxt        = sp_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    i1_nxt        = i1_r;
    i2_nxt        = i2_r;
    ilo_nxt       = ilo_r;
    ihi_nxt       = ihi_r;
    ii_nxt        = ii_r;
    j_nxt         = j_r;
    pv_nxt        = pv_r;
    prec_nxt      = prec_r;
    rec1_nxt      = rec1_r;
    rec2_nxt      = rec2_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_rec_nxt   = out_rec_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = {in_ch.record_key, in_ch.record_payload};
    ram_raddr     = r_r[AW-1:0];
    push_en       = 1'b0;
    push_lo       = '0;
    push_hi       = '0;
    plo           = '0;
    phi           = '0;

    case (state_r)
      S_LOAD: begin
        if (in_req) begin
          // A full store drops the request but the batch still ends on is_last.
          if (count_r < CW'(MAX_RECORDS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_ch.is_last) begin
            l_nxt     = '0;
            r_nxt     = idx_t'({1'b0, count_nxt}) - idx_t'(1);
            sp_nxt    = '0;
            state_nxt = S_TOP;
          end
        end
      end

      S_TOP: begin
        if (r_r > l_r) begin
          ram_raddr = r_r[AW-1:0];
          state_nxt = S_PIV;
        end else if (sp_r < SW'(2)) begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_POP1;
        end
      end

      S_POP1: begin
        r_nxt     = stack_r[SAW'(sp_r - SW'(1))];
        sp_nxt    = sp_r - SW'(1);
        state_nxt = S_POP2;
      end

      S_POP2: begin
        l_nxt     = stack_r[SAW'(sp_r - SW'(1))];
        sp_nxt    = sp_r - SW'(1);
        state_nxt = S_TOP;
      end

      S_PIV: begin
        pv_nxt    = rd_rank;
        prec_nxt  = ram_rdata;
        i1_nxt    = l_r - idx_t'(1);
        i2_nxt    = r_r;
        state_nxt = S_L_RD;
      end

      S_L_RD: begin
        i1_nxt    = i1_r + idx_t'(1);
        ram_raddr = i1_nxt[AW-1:0];
        state_nxt = S_L_CHK;
      end

      S_L_CHK: begin
        if (i1_r < r_r && pv_r > rd_rank) begin
          state_nxt = S_L_RD;
        end else begin
          rec1_nxt  = ram_rdata;
          state_nxt = S_R_RD;
        end
      end

      S_R_RD: begin
        i2_nxt    = i2_r - idx_t'(1);
        ram_raddr = i2_nxt[AW-1:0];
        state_nxt = S_R_CHK;
      end

      S_R_CHK: begin
        if (i2_r > i1_r && pv_r < rd_rank) begin
          state_nxt = S_R_RD;
        end else begin
          rec2_nxt  = ram_rdata;
          state_nxt = (i2_r <= i1_r) ? S_PSW1 : S_SW1;
        end
      end

      S_SW1: begin
        ram_we    = 1'b1;
        ram_waddr = i1_r[AW-1:0];
        ram_wdata = rec2_r;
        state_nxt = S_SW2;
      end

      S_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = i2_r[AW-1:0];
        ram_wdata = rec1_r;
        state_nxt = S_L_RD;
      end

      // The pivot record goes to the meeting point, that record moves to the right end.
      S_PSW1: begin
        ram_we    = 1'b1;
        ram_waddr = i1_r[AW-1:0];
        ram_wdata = prec_r;
        state_nxt = S_PSW2;
      end

      S_PSW2: begin
        ram_we    = 1'b1;
        ram_waddr = r_r[AW-1:0];
        ram_wdata = rec1_r;
        state_nxt = S_SPLIT;
      end

      // The larger side is deferred; the smaller side becomes the working range.
      S_SPLIT: begin
        if ((split_i - l_r) > (r_r - split_i)) begin
          plo   = l_r;
          phi   = split_i - idx_t'(1);
          l_nxt = split_i + idx_t'(1);
        end else begin
          plo   = split_i + idx_t'(1);
          phi   = r_r;
          r_nxt = split_i - idx_t'(1);
        end
        state_nxt = S_TOP;
        if (phi > plo) begin
          if (({1'b0, sp_r} + (SW+1)'(2)) > (SW+1)'(STACK_DEPTH)) begin
            // No stack room: finish that range here by insertion sort.
            ilo_nxt   = plo;
            ihi_nxt   = phi;
            ii_nxt    = plo + idx_t'(1);
            state_nxt = S_INS_OUT;
          end else begin
            push_en = 1'b1;
            push_lo = plo;
            push_hi = phi;
            sp_nxt  = sp_r + SW'(2);
          end
        end
      end

      S_INS_OUT: begin
        if (ii_r > ihi_r) begin
          state_nxt = S_TOP;
        end else begin
          j_nxt     = ii_r;
          ram_raddr = ii_r[AW-1:0];
          state_nxt = S_INS_CUR;
        end
      end

      S_INS_CUR: begin
        cur_nxt   = ram_rdata;
        ram_raddr = AW'(j_r - idx_t'(1));
        state_nxt = S_INS_CHK;
      end

      // The moving record is held aside and written once its slot is found.
      S_INS_CHK: begin
        if (rd_rank > rqs_rank(cur_r[RW-1:PAYLOAD_BITS], key_type_r)) begin
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = ram_rdata;
          j_nxt     = j_r - idx_t'(1);
          if (j_nxt > ilo_r) begin
            ram_raddr = AW'(j_r - idx_t'(2));
            state_nxt = S_INS_CHK;
          end else begin
            state_nxt = S_INS_FIN;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = j_r[AW-1:0];
          ram_wdata = cur_r;
          ii_nxt    = ii_r + idx_t'(1);
          state_nxt = S_INS_OUT;
        end
      end

      S_INS_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = cur_r;
        ii_nxt    = ii_r + idx_t'(1);
        state_nxt = S_INS_OUT;
      end

      S_OUT_RD: begin
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_OUT_LD;
      end

      S_OUT_LD: begin
        out_rec_nxt   = ram_rdata;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (k_r == count_r - CW'(1));
        out_ovf_nxt   = drop_r;
        state_nxt     = S_OUT_WAIT;
      end

      S_OUT_WAIT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt = '0;
            drop_nxt  = 1'b0;
            sp_nxt    = '0;
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      drop_r      <= 1'b0;
      sp_r        <= '0;
      key_type_r  <= KEY_S16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_req) begin
        key_type_r <= key_type_t'(cfg_ch.key_type);
      end
    end
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    i1_r       <= i1_nxt;
    i2_r       <= i2_nxt;
    ilo_r      <= ilo_nxt;
    ihi_r      <= ihi_nxt;
    ii_r       <= ii_nxt;
    j_r        <= j_nxt;
    pv_r       <= pv_nxt;
    prec_r     <= prec_nxt;
    rec1_r     <= rec1_nxt;
    rec2_r     <= rec2_nxt;
    cur_r      <= cur_nxt;
    k_r        <= k_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_rec_r  <= out_rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stack_r[SAW'(sp_r)]           <= push_lo;
      stack_r[SAW'(sp_r + SW'(1))]  <= push_hi;
    end
  end

  // A result is never offered while new records are being taken.
  `RQS_ALWAYS(a_no_overlap, !(out_ch.valid && in_ch.ready), "result offered during load")
  // The range stack never grows past its depth.
  `RQS_ALWAYS(a_sp_bound, sp_r <= SW'(STACK_DEPTH), "range stack overrun")
  // After the final result of a batch is taken, loading resumes.
  `RQS_NEXT(a_reload, out_ch.valid && out_ch.ready && out_ch.last_out, in_ch.ready, "no reload")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rqs_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int RANGE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 60;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
    logic        last;
  } record_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
    logic        last;
    logic        overflow;
  } sorted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rqs_in_if  #(.PAYLOAD_BITS(32)) in_if ();
  rqs_out_if #(.PAYLOAD_BITS(32)) out_if ();
  rqs_cfg_if cfg_if ();

  record_quicksort_by_key_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Model of the sorter: the batch being loaded, the compare mode and the range stack.
  logic [31:0] batch_key [CAPACITY];
  logic [31:0] batch_pay [CAPACITY];
  int          batch_len;
  bit          batch_lost;
  key_type_t   compare_mode;
  int          range_mem [RANGE_SLOTS];
  int          range_top;

  sorted_t sorted_due[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      calm;

  // Maps a key onto one signed scale according to the current compare mode.
  function automatic longint key_order(logic [31:0] k);
    case (compare_mode)
      KEY_S16: return longint'($signed(k[15:0]));
      KEY_S32: return longint'($signed(k));
      KEY_U16: return longint'(k[15:0]);
      default: return longint'(k);
    endcase
  endfunction

  function automatic void swap_records(int a, int b);
    logic [31:0] tk;
    logic [31:0] tp;
    tk = batch_key[a];
    tp = batch_pay[a];
    batch_key[a] = batch_key[b];
    batch_pay[a] = batch_pay[b];
    batch_key[b] = tk;
    batch_pay[b] = tp;
  endfunction

  // Defers a range to the stack, or finishes it in place by insertion when the stack is full.
  function automatic void defer_range(int lo, int hi);
    int i;
    int j;
    if (hi <= lo) return;
    if (range_top + 2 > RANGE_SLOTS) begin
      for (i = lo + 1; i <= hi; i++) begin
        j = i;
        while (j > lo && key_order(batch_key[j-1]) > key_order(batch_key[j])) begin
          swap_records(j - 1, j);
          j--;
        end
      end
      return;
    end
    range_mem[range_top] = lo;
    range_mem[range_top+1] = hi;
    range_top += 2;
  endfunction

  function automatic void quicksort_batch(int n);
    int lo;
    int hi;
    int i1;
    int i2;
    int p;
    longint pivot;
    lo = 0;
    hi = n - 1;
    range_top = 0;
    forever begin
      if (hi > lo) begin
        pivot = key_order(batch_key[hi]);
        i1 = lo - 1;
        i2 = hi;
        forever begin
          do i1++; while (i1 < hi && pivot > key_order(batch_key[i1]));
          do i2--; while (i2 > i1 && pivot < key_order(batch_key[i2]));
          if (i2 <= i1) break;
          swap_records(i1, i2);
        end
        swap_records(i1, hi);
        p = i1;
        if (p - lo > hi - p) begin
          defer_range(lo, p - 1);
          lo = p + 1;
        end else begin
          defer_range(p + 1, hi);
          hi = p - 1;
        end
      end else begin
        if (range_top < 2) break;
        hi = range_mem[range_top-1];
        lo = range_mem[range_top-2];
        range_top -= 2;
      end
    end
  endfunction

  // Called once per accepted record; a closing record sorts the batch and queues its results.
  function automatic void absorb_record(record_t r);
    sorted_t s;
    if (batch_len < CAPACITY) begin
      batch_key[batch_len] = r.key;
      batch_pay[batch_len] = r.payload;
      batch_len++;
    end else begin
      batch_lost = 1'b1;
    end
    if (!r.last) return;
    quicksort_batch(batch_len);
    for (int k = 0; k < batch_len; k++) begin
      s.key = batch_key[k];
      s.payload = batch_pay[k];
      s.last = (k == batch_len - 1);
      s.overflow = batch_lost;
      sorted_due.push_back(s);
    end
    batch_len = 0;
    batch_lost = 1'b0;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_record(record_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.record_key = r.key;
    in_if.record_payload = r.payload;
    in_if.is_last = r.last;
    do @(posedge clk); while (!in_if.ready);
    absorb_record(r);
    @(negedge clk);
  endtask

  // The register is written only while no request is outstanding, so the sorter is idle.
  task automatic set_mode(key_type_t m);
    in_if.valid = 1'b0;
    while (sorted_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.key_type = m;
    do @(posedge clk); while (!cfg_if.ready);
    compare_mode = m;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_batch(int n, bit few_keys);
    record_t r;
    for (int i = 0; i < n; i++) begin
      r.key = few_keys ? $urandom_range(0, 3) | ($urandom_range(0, 1) << 31) : $urandom;
      if ($urandom_range(0, 3) == 0) r.key[15] = ~r.key[15];
      r.payload = $urandom;
      r.last = (i == n - 1);
      send_record(r);
    end
  endtask

  // Directed records: a lone record, a batch of extreme keys whose order depends on the
  // compare mode, and a batch of equal keys.
  record_t directed [12] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1},
    '{32'h0000_8000, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_7FFF, 32'h0000_0001, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0002, 1'b0},
    '{32'h8000_0000, 32'h0000_0003, 1'b0},
    '{32'h0000_FFFF, 32'h0000_0004, 1'b0},
    '{32'h1234_0000, 32'h0000_0005, 1'b0},
    '{32'h0001_0000, 32'h0000_0006, 1'b0},
    '{32'h7FFF_FFFF, 32'h0000_0007, 1'b1},
    '{32'h0000_0005, 32'h0000_000A, 1'b0},
    '{32'h0000_0005, 32'h0000_000B, 1'b0},
    '{32'h0000_0005, 32'h0000_000C, 1'b1}
  };

  key_type_t random_modes [5] = '{KEY_S32, KEY_U16, KEY_U32, KEY_S16, KEY_S32};

  // The receiver: checks every accepted result against the oldest one due, then, outside the
  // calm phases, stalls for a random number of cycles before it accepts the next.
  initial begin
    int stall;
    sorted_t got;
    sorted_t want;
    out_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = '{out_if.sorted_key, out_if.sorted_payload, out_if.last_out, out_if.overflow};
        if (sorted_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result key %h payload %h", got.key, got.payload);
        end else begin
          want = sorted_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected key %h pay %h last %b ovf %b,",
                       want.key, want.payload, want.last, want.overflow,
                       " got key %h pay %h last %b ovf %b",
                       got.key, got.payload, got.last, got.overflow);
          end
        end
        stall = draw_gap();
      end
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.record_key = '0;
    in_if.record_payload = '0;
    in_if.is_last = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.key_type = KEY_S16;
    batch_len = 0;
    batch_lost = 1'b0;
    compare_mode = KEY_S16;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The directed records run first at the reset mode, then again with unsigned 32-bit keys.
    foreach (directed[i]) send_record(directed[i]);
    set_mode(KEY_U32);
    calm = 1'b1;
    foreach (directed[i]) send_record(directed[i]);

    // Random batches, mostly short, each phase setting a mode and an idling style.
    foreach (random_modes[m]) begin
      set_mode(random_modes[m]);
      calm = (m % 2 == 1);
      if (m == 0) send_batch(CAPACITY + 2, 1'b0);
      for (int b = 0; b < 2; b++) send_batch($urandom_range(1, 4), b == 1);
    end

    in_if.valid = 1'b0;
    while (sorted_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/rqs_pkg.sv
src/rqs_if.sv
src/rqs_ram.sv
src/record_quicksort_by_key_unit.sv
bench/testbench.sv
